FILE: rtl/core/sph_density_summation_assert.svh
// Assertion macros for the SPH density summation block.
// Used by the port checker; no other dependencies.
`ifndef SPH_DENSITY_SUMMATION_ASSERT_SVH
`define SPH_DENSITY_SUMMATION_ASSERT_SVH
// Implication checked at every rising clock edge, off during reset.
`define SPH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, off during reset.
`define SPH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/core/sph_pkg.sv
// Shared types and constants for the SPH density summation block.
// No dependencies.
package sph_pkg;
   localparam int FRAC_BITS = 16;
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;
   localparam int SHIFT_S = 2 * FRAC_BITS - 30;
   localparam logic [31:0] H_RESET = 32'd1 << FRAC_BITS;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DIFF, ST_DIVX, ST_DIVY, ST_DIVZ, ST_SQX, ST_SQY, ST_SQZ,
      ST_SQRT, ST_A2, ST_A3, ST_B2, ST_B3, ST_W, ST_MW, ST_MWP, ST_H2,
      ST_H3, ST_DIV, ST_ACC, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic wide;
   } div_ctl_type;
endpackage

FILE: rtl/core/sph_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sph_pkg.
module sph_divider
   import sph_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_ctl_type  ctl,
   input  logic [127:0] num,
   input  logic [127:0] den,
   output logic         done,
   output logic [127:0] quot
);
   logic [127:0] num_ff, num_in, rem_ff, rem_in, quot_ff, quot_in, den_ff, den_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic [128:0] trial;
   logic [127:0] shifted;
   logic         take;

   always_comb begin
      shifted = {rem_ff[126:0], num_ff[127]};
      trial = {1'b0, shifted} - {1'b0, den_ff};
      take = !trial[128] && (rem_ff[127] == 1'b0);
      done = busy_ff && (cnt_ff == 8'd1);
      num_in = num_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         num_in = {num_ff[126:0], 1'b0};
         rem_in = take ? trial[127:0] : shifted;
         quot_in = {quot_ff[126:0], take};
         cnt_in = cnt_ff - 8'd1;
         if (cnt_ff == 8'd1) begin
            busy_in = 1'b0;
         end
      end
      if (ctl.start) begin
         busy_in = 1'b1;
         rem_in = '0;
         quot_in = '0;
         den_in = den;
         num_in = ctl.wide ? num : {num[63:0], 64'd0};
         cnt_in = ctl.wide ? 8'd128 : 8'd64;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      den_ff <= den_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
   end

   assign quot = {quot_ff[126:0], take};
endmodule

FILE: rtl/core/sph_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Depends on sph_pkg.
module sph_sqrt
   import sph_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic        busy_ff, busy_in;

   always_comb begin
      v_in = v_ff;
      r_in = r_ff;
      bit_in = bit_ff;
      busy_in = busy_ff;
      done = 1'b0;
      if (start) begin
         v_in = value;
         r_in = '0;
         bit_in = 64'd1 << 62;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= r_ff + bit_ff) begin
            v_in = v_ff - (r_ff + bit_ff);
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      r_ff <= r_in;
      bit_ff <= bit_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign root = r_in[31:0];
endmodule

FILE: rtl/core/sph_density_summation.sv
// SPH density summation top level: sequencer, serial multiplier and serial units.
// Per request: begin goes to ST_OUT; source goes to ST_OUT after the box test when outside,
// after the squares when q > 2, else three narrow divides, eleven multiplies, a root and a wide divide.
// One transaction at a time; a pending last result stalls only ST_OUT.
// Synchronous active-high reset: sink at origin, h = 1.0, sum cleared.
// Depends on sph_pkg, sph_divider, sph_sqrt.
module sph_density_summation
   import sph_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_amount,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_density
);
   state_type    st_ff, st_in;
   logic [31:0]  sx_ff, sy_ff, sz_ff, h_ff;
   logic [63:0]  sum_ff;
   logic [31:0]  px_ff, py_ff, pz_ff, m_ff;
   logic         last_ff;
   logic [32:0]  dx_ff, dy_ff, dz_ff;
   logic [31:0]  ux_ff, uy_ff, uz_ff;
   logic [63:0]  q2_ff, a_ff, t_ff, b_ff, w_ff, c_ff;
   logic [31:0]  q_ff;
   logic [127:0] num_ff;
   logic         rv_ff;
   logic [63:0]  rd_ff;
   logic [63:0]  mul_a;
   logic [31:0]  mul_b;
   logic [95:0]  mul_prod;
   logic         mul_done;
   logic [63:0]  ma_ff, ma_in;
   logic [95:0]  mp_ff, mp_in;
   logic [5:0]   mcnt_ff, mcnt_in;
   logic         mbusy_ff, mbusy_in, mdone_ff, mdone_in, mgo_ff, mgo_in;
   logic [64:0]  msum;
   logic         div_done, sq_done;
   logic [127:0] div_q, div_num, div_den;
   logic [31:0]  sq_root;
   div_ctl_type  dctl;
   logic         sq_start;
   logic [63:0]  contrib;
   logic [33:0]  h2;
   logic [32:0]  adx, ady, adz;
   logic         outside;

   function automatic logic [32:0] absd(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] d;
      d = {a[31], a} - {b[31], b};
      return d[32] ? (33'd0 - d) : d;
   endfunction

   assign adx = absd(sx_ff, px_ff);
   assign ady = absd(sy_ff, py_ff);
   assign adz = absd(sz_ff, pz_ff);
   assign h2 = {1'b0, h_ff, 1'b0};
   assign outside = (h_ff == '0) || ({1'b0, adx} > h2) || ({1'b0, ady} > h2)
                    || ({1'b0, adz} > h2);

   always_comb begin
      unique case (st_ff)
         ST_SQX:  begin mul_a = {32'd0, ux_ff}; mul_b = ux_ff; end
         ST_SQY:  begin mul_a = {32'd0, uy_ff}; mul_b = uy_ff; end
         ST_SQZ:  begin mul_a = {32'd0, uz_ff}; mul_b = uz_ff; end
         ST_A2:   begin mul_a = a_ff; mul_b = a_ff[31:0]; end
         ST_A3:   begin mul_a = t_ff; mul_b = a_ff[31:0]; end
         ST_B2:   begin mul_a = b_ff; mul_b = b_ff[31:0]; end
         ST_B3:   begin mul_a = t_ff; mul_b = b_ff[31:0]; end
         ST_MW:   begin mul_a = w_ff; mul_b = m_ff; end
         ST_MWP:  begin mul_a = c_ff; mul_b = INV_PI_Q32; end
         ST_H2:   begin mul_a = {32'd0, h_ff}; mul_b = h_ff; end
         ST_H3:   begin mul_a = t_ff; mul_b = h_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // shift-add multiplier, one multiplier bit per cycle
   always_comb begin
      msum = {1'b0, mp_ff[95:32]} + (mp_ff[0] ? {1'b0, ma_ff} : 65'd0);
      ma_in = ma_ff;
      mp_in = mp_ff;
      mcnt_in = mcnt_ff;
      mbusy_in = mbusy_ff;
      mdone_in = 1'b0;
      if (mgo_ff) begin
         ma_in = mul_a;
         mp_in = {64'd0, mul_b};
         mcnt_in = 6'd32;
         mbusy_in = 1'b1;
      end else if (mbusy_ff) begin
         mp_in = {msum, mp_ff[31:1]};
         mcnt_in = mcnt_ff - 6'd1;
         if (mcnt_ff == 6'd1) begin
            mbusy_in = 1'b0;
            mdone_in = 1'b1;
         end
      end
   end
   assign mul_done = mdone_ff;
   assign mul_prod = mp_ff;

   always_comb begin
      unique case (st_in)
         ST_SQX, ST_SQY, ST_SQZ, ST_A2, ST_A3, ST_B2, ST_B3, ST_MW, ST_MWP, ST_H2,
         ST_H3:   mgo_in = (st_in != st_ff);
         default: mgo_in = 1'b0;
      endcase
   end

   always_comb begin
      dctl.start = 1'b0;
      dctl.wide = 1'b0;
      sq_start = 1'b0;
      unique case (st_ff)
         ST_DIFF: dctl.start = !outside;
         ST_DIVX, ST_DIVY: dctl.start = div_done;
         ST_H3: begin dctl.start = mul_done; dctl.wide = 1'b1; end
         ST_SQZ: sq_start = mul_done && ((q2_ff + mul_prod[63:0]) <= (64'd4 << 60));
         default: ;
      endcase
   end

   assign div_num = (st_ff == ST_H3) ? num_ff :
                    {64'd0, 1'b0, ((st_ff == ST_DIFF) ? adx :
                    ((st_ff == ST_DIVX) ? dy_ff : dz_ff)), 30'd0};
   assign div_den = (st_ff == ST_H3) ?
                    ({32'd0, mul_prod} << (SHIFT_S >= 0 ? 0 : -SHIFT_S)) : {96'd0, h_ff};

   sph_divider u_div (
      .clock(clock), .reset(reset), .ctl(dctl), .num(div_num), .den(div_den),
      .done(div_done), .quot(div_q));

   sph_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .value(q2_ff + mul_prod[63:0]),
      .done(sq_done), .root(sq_root));

   assign contrib = (div_q[127:64] != '0) ? '1 : div_q[63:0];

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (req_valid && req_ready) st_in = req_kind ? ST_DIFF : ST_OUT;
         ST_DIFF: st_in = outside ? ST_OUT : ST_DIVX;
         ST_DIVX: if (div_done) st_in = ST_DIVY;
         ST_DIVY: if (div_done) st_in = ST_DIVZ;
         ST_DIVZ: if (div_done) st_in = ST_SQX;
         ST_SQX:  if (mul_done) st_in = ST_SQY;
         ST_SQY:  if (mul_done) st_in = ST_SQZ;
         ST_SQZ:  if (mul_done) st_in = sq_start ? ST_SQRT : ST_OUT;
         ST_SQRT: if (sq_done) st_in = ST_A2;
         ST_A2:   if (mul_done) st_in = ST_A3;
         ST_A3:   if (mul_done) st_in = ST_B2;
         ST_B2:   if (mul_done) st_in = ST_B3;
         ST_B3:   if (mul_done) st_in = ST_W;
         ST_W:    st_in = ST_MW;
         ST_MW:   if (mul_done) st_in = ST_MWP;
         ST_MWP:  if (mul_done) st_in = ST_H2;
         ST_H2:   if (mul_done) st_in = ST_H3;
         ST_H3:   if (mul_done) st_in = ST_DIV;
         ST_DIV:  if (div_done) st_in = ST_ACC;
         ST_ACC:  st_in = ST_OUT;
         ST_OUT:  if (!last_ff || !rv_ff) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   assign req_ready = (st_ff == ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_density = rd_ff;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         px_ff <= req_pos_x; py_ff <= req_pos_y; pz_ff <= req_pos_z;
         m_ff <= req_amount; last_ff <= req_last;
      end
      if (st_ff == ST_DIFF) begin dx_ff <= adx; dy_ff <= ady; dz_ff <= adz; end
      if (div_done && st_ff == ST_DIVX) ux_ff <= div_q[31:0];
      if (div_done && st_ff == ST_DIVY) uy_ff <= div_q[31:0];
      if (div_done && st_ff == ST_DIVZ) uz_ff <= div_q[31:0];
      ma_ff <= ma_in;
      mp_ff <= mp_in;
      if (mul_done && st_ff == ST_SQX) q2_ff <= mul_prod[63:0];
      if (mul_done && st_ff == ST_SQY) q2_ff <= q2_ff + mul_prod[63:0];
      if (sq_done) begin
         q_ff <= sq_root;
         a_ff <= (Q30_ONE << 1) - {32'd0, sq_root};
         b_ff <= Q30_ONE - {32'd0, sq_root};
      end
      if (mul_done && (st_ff == ST_A2 || st_ff == ST_B2)) t_ff <= mul_prod[93:30];
      if (mul_done && st_ff == ST_H2) t_ff <= mul_prod[63:0];
      if (mul_done && st_ff == ST_A3) w_ff <= mul_prod[95:32];
      if (mul_done && st_ff == ST_B3) c_ff <= mul_prod[93:30];
      if (st_ff == ST_W && q_ff < Q30_ONE[31:0]) w_ff <= (c_ff > w_ff) ? '0 : w_ff - c_ff;
      if (mul_done && st_ff == ST_MW) c_ff <= mul_prod[63:0];
      if (mul_done && st_ff == ST_MWP)
         num_ff <= {32'd0, mul_prod} << (SHIFT_S >= 0 ? SHIFT_S : 0);
      if (div_done && st_ff == ST_DIV) c_ff <= contrib;
      if (reset) begin
         st_ff <= ST_IDLE;
         sx_ff <= '0; sy_ff <= '0; sz_ff <= '0; h_ff <= H_RESET; sum_ff <= '0;
         rv_ff <= 1'b0; rd_ff <= '0;
         mcnt_ff <= '0; mbusy_ff <= 1'b0; mdone_ff <= 1'b0; mgo_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         mcnt_ff <= mcnt_in;
         mbusy_ff <= mbusy_in;
         mdone_ff <= mdone_in;
         mgo_ff <= mgo_in;
         if (req_valid && req_ready && !req_kind) begin
            sx_ff <= req_pos_x; sy_ff <= req_pos_y; sz_ff <= req_pos_z;
            h_ff <= req_amount; sum_ff <= '0;
         end
         if (st_ff == ST_ACC)
            sum_ff <= (sum_ff > ~c_ff) ? '1 : sum_ff + c_ff;
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         if (st_ff == ST_OUT && last_ff && !rv_ff) begin
            rv_ff <= 1'b1;
            rd_ff <= sum_ff;
         end
      end
   end
endmodule

FILE: rtl/core/sph_checker.sv
// Port-level checker for the SPH density summation block, with its bind.
// Depends on sph_density_summation_assert.svh.
`include "sph_density_summation_assert.svh"
module sph_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_density
);
   `SPH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_density), "rsp dropped")
   `SPH_ASSERT_NEXT(a_no_take, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   `SPH_ASSERT_IMP(a_rsp_known, clock, reset, rsp_valid, !$isunknown(rsp_density), "rsp unknown")
   `SPH_ASSERT_NEXT(a_begin_last, clock, reset, req_valid && req_ready && !req_kind && !req_last, !rsp_valid || $past(rsp_valid), "spurious rsp")
endmodule

bind sph_density_summation sph_checker u_chk (.*);
